@@ src/tea_pkg.sv @@
package tea_pkg;

  typedef logic [31:0] word_t;

  // The four key words, index 0 is key_word0.
  typedef word_t [3:0] key_t;

  typedef logic [1:0] cfg_idx_t;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_t;

  localparam cfg_idx_t REG_KEY_WORD0 = 2'd0;
  localparam cfg_idx_t REG_KEY_WORD1 = 2'd1;
  localparam cfg_idx_t REG_KEY_WORD2 = 2'd2;
  localparam cfg_idx_t REG_KEY_WORD3 = 2'd3;

  localparam word_t DELTA_STEP = 32'h9e37_79b9;
  localparam int unsigned ROUNDS_DEFAULT = 8;

  // Data that travels down the round pipeline with each item.
  typedef struct packed {
    cmd_t  cmd;
    word_t v0;
    word_t v1;
  } stage_t;

endpackage

@@ src/tea_in_if.sv @@
interface tea_in_if;
  import tea_pkg::*;

  logic          valid;
  logic          ready;
  cmd_t          cmd;
  word_t         block_lo;
  word_t         block_hi;

  modport source (output valid, output cmd, output block_lo, output block_hi, input ready);
  modport sink   (input valid, input cmd, input block_lo, input block_hi, output ready);
endinterface

@@ src/tea_out_if.sv @@
interface tea_out_if;
  import tea_pkg::*;

  logic  valid;
  logic  ready;
  word_t out_lo;
  word_t out_hi;

  modport source (output valid, output out_lo, output out_hi, input ready);
  modport sink   (input valid, input out_lo, input out_hi, output ready);
endinterface

@@ src/tea_cfg_if.sv @@
interface tea_cfg_if;
  import tea_pkg::*;

  logic     valid;
  logic     ready;
  cfg_idx_t index;
  word_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/tea_half_round.sv @@
module tea_half_round #(
  parameter bit             HALF    = 1'b0,
  parameter tea_pkg::word_t SUM_ENC = '0,
  parameter tea_pkg::word_t SUM_DEC = '0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tea_pkg::key_t   key,
  input  logic            in_valid,
  output logic            in_ready,
  input  tea_pkg::stage_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output tea_pkg::stage_t out_data
);
  import tea_pkg::*;

  logic   valid_r;
  stage_t data_r;
  stage_t data_nxt;

  logic   upd_v0;
  logic   is_dec;
  word_t  src;
  word_t  dst;
  word_t  ka;
  word_t  kb;
  word_t  sum;
  word_t  mix;
  word_t  res;

  // In the first half-round encryption updates v0 and decryption updates v1;
  // the second half-round does the opposite. The updated word always pairs
  // v0 with key words 0 and 1 and v1 with key words 2 and 3.
  always_comb begin
    is_dec = (in_data.cmd == CMD_DECRYPT);
    upd_v0 = (HALF == 1'b0) ^ is_dec;
    src    = upd_v0 ? in_data.v1 : in_data.v0;
    dst    = upd_v0 ? in_data.v0 : in_data.v1;
    ka     = upd_v0 ? key[0] : key[2];
    kb     = upd_v0 ? key[1] : key[3];
    sum    = is_dec ? SUM_DEC : SUM_ENC;
    mix    = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
    res    = is_dec ? (dst - mix) : (dst + mix);
    data_nxt     = in_data;
    if (upd_v0) begin
      data_nxt.v0 = res;
    end else begin
      data_nxt.v1 = res;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ src/tea_block_cipher_8_rounds.sv @@
// TEA block cipher with a reduced, fixed round count (ROUNDS, 8 by default).
//
// Items arrive on in_ch: cmd selects encrypt or decrypt, block_lo and
// block_hi are the two words of the 64-bit block. Each item gives exactly one
// result item on out_ch carrying out_lo and out_hi. Both channels use a
// valid/ready handshake; an item moves at a clock edge where both are high.
// The 128-bit key is held in four words written through cfg_ch, register
// index 0 to 3 for key_word0 to key_word3. The port is always ready. Keys
// should only be changed while no item is in flight.
//
// Every round is split into two half-rounds, and each half-round is one
// register stage, so the pipeline is 2*ROUNDS stages deep. An item passes
// through the stage registers in order on its way from in_ch to out_ch.
// While out_ch keeps ready high, one item enters and one leaves every cycle.
//
// Each stage holds its item while the stage after it is full and stalled, so
// when the receiver drops ready the pipeline fills up and in_ch keeps taking
// items until every stage is occupied. Nothing is lost or repeated. Reset
// (rst_n low, synchronous) empties the pipeline and clears the key to zero.
module tea_block_cipher_8_rounds #(
  parameter int unsigned ROUNDS = tea_pkg::ROUNDS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  tea_in_if.sink    in_ch,
  tea_out_if.source out_ch,
  tea_cfg_if.sink   cfg_ch
);
  import tea_pkg::*;

  localparam int unsigned STAGES = 2 * ROUNDS;

  key_t key_r;

  // Key registers; an index that names no key word cannot occur with a
  // two-bit index, so every write lands in one of the four words.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_KEY_WORD0: key_r[0] <= cfg_ch.data;
        REG_KEY_WORD1: key_r[1] <= cfg_ch.data;
        REG_KEY_WORD2: key_r[2] <= cfg_ch.data;
        REG_KEY_WORD3: key_r[3] <= cfg_ch.data;
        default:       key_r    <= key_r;
      endcase
    end
  end

  // Handshake chain between stages: entry 0 is the input channel, entry
  // STAGES is the output channel.
  logic   st_valid [STAGES+1];
  logic   st_ready [STAGES+1];
  stage_t st_data  [STAGES+1];

  assign st_valid[0]   = in_ch.valid;
  assign in_ch.ready   = st_ready[0];
  assign st_data[0].cmd = cmd_t'(in_ch.cmd);
  assign st_data[0].v0  = in_ch.block_lo;
  assign st_data[0].v1  = in_ch.block_hi;

  genvar s;
  generate
    for (s = 0; s < STAGES; s++) begin : g_stage
      // The running sum is fixed per round: encryption uses delta*(r+1),
      // decryption walks down from delta*ROUNDS.
      localparam word_t SUM_E =
        word_t'(64'(DELTA_STEP) * 64'(s / 2 + 1));
      localparam word_t SUM_D =
        word_t'(64'(DELTA_STEP) * 64'(ROUNDS - s / 2));

      tea_half_round #(
        .HALF    (s % 2 == 1),
        .SUM_ENC (SUM_E),
        .SUM_DEC (SUM_D)
      ) u_half (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key_r),
        .in_valid  (st_valid[s]),
        .in_ready  (st_ready[s]),
        .in_data   (st_data[s]),
        .out_valid (st_valid[s+1]),
        .out_ready (st_ready[s+1]),
        .out_data  (st_data[s+1])
      );
    end
  endgenerate

  assign out_ch.valid      = st_valid[STAGES];
  assign st_ready[STAGES]  = out_ch.ready;
  assign out_ch.out_lo     = st_data[STAGES].v0;
  assign out_ch.out_hi     = st_data[STAGES].v1;

endmodule
